// File: hdl/assert_macros.svh
// assertion macros used by the controller (vga_ctrl)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every rising edge outside reset
`define VGA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// overlapping implication checked on every rising edge outside reset
`define VGA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/vga_pkg.sv
// shared types, codes and defaults of the voxel grid accumulator
package vga_pkg;

  localparam int unsigned GridXDef = 64;
  localparam int unsigned GridYDef = 64;
  localparam int unsigned GridZDef = 16;

  localparam logic [15:0] CountMax = 16'hFFFF;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [2:0] CFG_REF_X   = 3'd0;
  localparam logic [2:0] CFG_REF_Y   = 3'd1;
  localparam logic [2:0] CFG_REF_Z   = 3'd2;
  localparam logic [2:0] CFG_INV_RES = 3'd3;
  localparam logic [2:0] CFG_MIN_PTS = 3'd4;

  localparam logic [31:0] InvResReset = 32'd65536;
  localparam logic [15:0] MinPtsReset = 16'd1;

  typedef struct packed {
    logic               op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [5:0]         cell_x;
    logic [5:0]         cell_y;
    logic [3:0]         cell_z;
  } vga_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        used;
    logic [15:0] point_count;
    logic [7:0]  avg_red;
    logic [7:0]  avg_green;
    logic [7:0]  avg_blue;
  } vga_res_t;

  typedef struct packed {
    logic [15:0] cnt;
    logic [23:0] red_sum;
    logic [23:0] green_sum;
    logic [23:0] blue_sum;
  } vga_entry_t;

  // controller to datapath
  typedef struct packed {
    logic       clr;
    logic       load;
    logic       mul;
    logic       chk;
    logic [1:0] axis;
    logic       addr;
    logic       rd;
    logic       upd;
    logic       div;
    logic       emit;
  } vga_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic op_rd;
    logic outside;
    logic do_div;
  } vga_sts_t;

endpackage

// File: hdl/vga_ctrl.sv
// sequencer for clearing, index calculation, memory access and division
`include "assert_macros.svh"

module vga_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output logic          done_o,
  output vga_pkg::vga_ctl_t ctl_o,
  input  vga_pkg::vga_sts_t sts_i
);
  import vga_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL, S_CHK, S_ADDR, S_RD, S_UPD, S_DIV, S_EMIT
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic [2:0] div_cnt_q, div_cnt_d;
  logic       done_q;
  logic       div_s;

  always_comb begin
    state_d   = state_q;
    axis_d    = axis_q;
    div_cnt_d = div_cnt_q;
    ctl_o     = '0;
    ctl_o.axis = axis_q;
    case (state_q)
      S_CLEAR: begin
        ctl_o.clr = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          axis_d = 2'd0;
          state_d = sts_i.op_rd ? S_ADDR : S_MUL;
        end
      end
      S_MUL: begin
        ctl_o.mul = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        ctl_o.chk = 1'b1;
        if (axis_q == 2'd2) begin
          state_d = S_ADDR;
        end else begin
          axis_d = axis_q + 2'd1;
          state_d = S_MUL;
        end
      end
      S_ADDR: begin
        ctl_o.addr = 1'b1;
        state_d = sts_i.outside ? S_EMIT : S_RD;
      end
      S_RD: begin
        ctl_o.rd = 1'b1;
        state_d = S_UPD;
      end
      S_UPD: begin
        ctl_o.upd = 1'b1;
        div_cnt_d = 3'd0;
        state_d = sts_i.do_div ? S_DIV : S_EMIT;
      end
      S_DIV: begin
        ctl_o.div = 1'b1;
        div_cnt_d = div_cnt_q + 3'd1;
        if (div_cnt_q == 3'd7) state_d = S_EMIT;
      end
      S_EMIT: begin
        ctl_o.emit = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      axis_q    <= 2'd0;
      div_cnt_q <= 3'd0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      axis_q    <= axis_d;
      div_cnt_q <= div_cnt_d;
      done_q    <= (state_q == S_EMIT);
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign div_s  = (state_q == S_DIV);

  `VGA_ASSERT_IMPL(a_done_idle, clk_i, rst_ni, done_q, state_q == S_IDLE, "strobe outside idle")
  `VGA_ASSERT(a_one_src, clk_i, rst_ni, $onehot0({ctl_o.clr, ctl_o.upd, ctl_o.load}), "overlap")
  `VGA_ASSERT_IMPL(a_div_upd, clk_i, rst_ni, $rose(div_s), $past(state_q) == S_UPD, "bad div entry")

endmodule

// File: hdl/vga_datapath.sv
// config registers, index multiplier, voxel memory and colour dividers
module vga_datapath #(
  parameter int unsigned GRID_X = vga_pkg::GridXDef,
  parameter int unsigned GRID_Y = vga_pkg::GridYDef,
  parameter int unsigned GRID_Z = vga_pkg::GridZDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vga_pkg::vga_cmd_t cmd_i,
  input  logic              cfg_valid_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  vga_pkg::vga_ctl_t ctl_i,
  output vga_pkg::vga_sts_t sts_o,
  output vga_pkg::vga_res_t result_o
);
  import vga_pkg::*;

  localparam int unsigned Cells = GRID_X * GRID_Y * GRID_Z;
  localparam int unsigned AW = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int unsigned XW = (GRID_X > 1) ? $clog2(GRID_X) : 1;
  localparam int unsigned YW = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
  localparam int unsigned ZW = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;

  // configuration
  logic [31:0] ref_x_q, ref_y_q, ref_z_q, inv_q;
  logic [15:0] min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_x_q <= '0;
      ref_y_q <= '0;
      ref_z_q <= '0;
      inv_q   <= InvResReset;
      min_q   <= MinPtsReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_REF_X:   ref_x_q <= cfg_data_i;
        CFG_REF_Y:   ref_y_q <= cfg_data_i;
        CFG_REF_Z:   ref_z_q <= cfg_data_i;
        CFG_INV_RES: inv_q   <= cfg_data_i;
        CFG_MIN_PTS: min_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // item registers
  logic              op_q;
  logic [2:0][31:0]  mag_q;
  logic [2:0]        neg_q;
  logic [2:0][7:0]   col_q;
  logic [5:0]        cx_q, cy_q;
  logic [3:0]        cz_q;
  logic [XW-1:0]     ix_q;
  logic [YW-1:0]     iy_q;
  logic [ZW-1:0]     iz_q;
  logic              out_q;
  logic [63:0]       prod_q;
  logic [AW-1:0]     addr_q;
  logic [AW-1:0]     clr_cnt_q;
  vga_entry_t        rdata_q;
  logic [1:0]        r_status_q;
  logic              r_used_q;
  logic [15:0]       r_cnt_q;
  logic [2:0][23:0]  rem_q;
  logic [2:0][7:0]   quo_q;
  logic [23:0]       dvs_q;
  vga_res_t          result_q;

  logic [2:0][31:0] pos_s, ref_s;
  logic [2:0][32:0] diff_s;
  logic             rd_out_s;
  logic [31:0]      im_s, size_s;
  logic             bad_s;
  logic [31:0]      sx_s, sy_s, sz_s, addr_s;
  logic             full_s, used_s;

  assign pos_s = {cmd_i.pos_z, cmd_i.pos_y, cmd_i.pos_x};
  assign ref_s = {ref_z_q, ref_y_q, ref_x_q};

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff_s[a] = {pos_s[a][31], pos_s[a]} - {ref_s[a][31], ref_s[a]};
    end
  end

  assign rd_out_s = (32'(cmd_i.cell_x) >= 32'(GRID_X)) || (32'(cmd_i.cell_y) >= 32'(GRID_Y))
                 || (32'(cmd_i.cell_z) >= 32'(GRID_Z));

  assign im_s = prod_q[63:32];
  always_comb begin
    case (ctl_i.axis)
      2'd0:    size_s = 32'(GRID_X);
      2'd1:    size_s = 32'(GRID_Y);
      default: size_s = 32'(GRID_Z);
    endcase
  end
  assign bad_s = (neg_q[ctl_i.axis] && (im_s != 32'd0)) || (im_s >= size_s);

  assign sx_s = (op_q == OP_READ) ? 32'(cx_q) : 32'(ix_q);
  assign sy_s = (op_q == OP_READ) ? 32'(cy_q) : 32'(iy_q);
  assign sz_s = (op_q == OP_READ) ? 32'(cz_q) : 32'(iz_q);
  assign addr_s = (sx_s * 32'(GRID_Y) + sy_s) * 32'(GRID_Z) + sz_s;

  assign full_s = (rdata_q.cnt == CountMax);
  assign used_s = (rdata_q.cnt >= min_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q <= cmd_i.op;
      for (int a = 0; a < 3; a++) begin
        neg_q[a] <= diff_s[a][32];
        mag_q[a] <= diff_s[a][32] ? 32'(-diff_s[a]) : diff_s[a][31:0];
      end
      col_q <= {cmd_i.blue, cmd_i.green, cmd_i.red};
      cx_q  <= cmd_i.cell_x;
      cy_q  <= cmd_i.cell_y;
      cz_q  <= cmd_i.cell_z;
      out_q <= (cmd_i.op == OP_READ) && rd_out_s;
      r_status_q <= ((cmd_i.op == OP_READ) && rd_out_s) ? ST_OUTSIDE : ST_OK;
      r_used_q <= 1'b0;
      r_cnt_q  <= '0;
      quo_q    <= '0;
    end
    if (ctl_i.mul) begin
      prod_q <= 64'(mag_q[ctl_i.axis]) * 64'(inv_q);
    end
    if (ctl_i.chk) begin
      if (bad_s) begin
        out_q      <= 1'b1;
        r_status_q <= ST_OUTSIDE;
      end
      case (ctl_i.axis)
        2'd0:    ix_q <= im_s[XW-1:0];
        2'd1:    iy_q <= im_s[YW-1:0];
        default: iz_q <= im_s[ZW-1:0];
      endcase
    end
    if (ctl_i.addr) begin
      addr_q <= addr_s[AW-1:0];
    end
    if (ctl_i.upd) begin
      if (op_q == OP_READ) begin
        r_cnt_q  <= rdata_q.cnt;
        r_used_q <= used_s;
        rem_q    <= {rdata_q.blue_sum, rdata_q.green_sum, rdata_q.red_sum};
        dvs_q    <= {1'b0, rdata_q.cnt, 7'd0};
      end else if (full_s) begin
        r_status_q <= ST_FULL;
        r_cnt_q    <= CountMax;
      end else begin
        r_cnt_q <= rdata_q.cnt + 16'd1;
      end
    end
    // restoring division, one quotient bit per step
    if (ctl_i.div) begin
      for (int c = 0; c < 3; c++) begin
        if (rem_q[c] >= dvs_q) begin
          rem_q[c] <= rem_q[c] - dvs_q;
          quo_q[c] <= {quo_q[c][6:0], 1'b1};
        end else begin
          quo_q[c] <= {quo_q[c][6:0], 1'b0};
        end
      end
      dvs_q <= dvs_q >> 1;
    end
    if (ctl_i.emit) begin
      result_q.status      <= r_status_q;
      result_q.used        <= r_used_q;
      result_q.point_count <= r_cnt_q;
      result_q.avg_red     <= quo_q[0];
      result_q.avg_green   <= quo_q[1];
      result_q.avg_blue    <= quo_q[2];
    end
  end

  // voxel store, cleared by a sweep after reset
  vga_entry_t mem [Cells];
  vga_entry_t wdata_s;
  logic       we_s;
  logic [AW-1:0] waddr_s;

  assign we_s = ctl_i.clr || (ctl_i.upd && (op_q == OP_INSERT) && !full_s);
  assign waddr_s = ctl_i.clr ? clr_cnt_q : addr_q;
  always_comb begin
    if (ctl_i.clr) begin
      wdata_s = '0;
    end else begin
      wdata_s.cnt       = rdata_q.cnt + 16'd1;
      wdata_s.red_sum   = rdata_q.red_sum + 24'(col_q[0]);
      wdata_s.green_sum = rdata_q.green_sum + 24'(col_q[1]);
      wdata_s.blue_sum  = rdata_q.blue_sum + 24'(col_q[2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_s) mem[waddr_s] <= wdata_s;
    if (ctl_i.rd) rdata_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (ctl_i.clr) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  assign sts_o = '{
    clr_done: (32'(clr_cnt_q) == Cells - 1),
    op_rd:    op_q,
    outside:  out_q,
    do_div:   (op_q == OP_READ) && used_s && (rdata_q.cnt != 16'd0)
  };
  assign result_o = result_q;

endmodule

// File: hdl/voxel_grid_accumulator_core.sv
// top level of the voxel grid accumulator
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------
//  command  | start_i, busy_o         | cmd_i (vga_cmd_t)
//  result   | done_o strobe           | result_o (vga_res_t)
//  config   | cfg_valid_i, cfg_ready_o| cfg_index_i, cfg_data_i
//
// an insert runs three multiply and check passes on the shared 32x32 index
// multiplier, then address, memory read, update and result, skipping the memory
// read and update for a point outside the grid; a read runs address, memory read,
// update, bit-serial colour division and result, skipping the division for a
// cell below the threshold or empty, and goes from address to result for a
// cell outside the grid; after reset a clearing sweep writes every voxel (65536
// by default) with busy_o high; config writes are taken at any time; the
// receiver cannot stall: each result is flagged on done_o for one cycle only
module voxel_grid_accumulator_core #(
  parameter int unsigned GRID_X = vga_pkg::GridXDef,
  parameter int unsigned GRID_Y = vga_pkg::GridYDef,
  parameter int unsigned GRID_Z = vga_pkg::GridZDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  vga_pkg::vga_cmd_t cmd_i,
  output logic              done_o,
  output vga_pkg::vga_res_t result_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);
  import vga_pkg::*;

  vga_ctl_t ctl;
  vga_sts_t sts;
  vga_sts_t sts_ctrl;
  logic     busy;

  assign cfg_ready_o = 1'b1;
  assign busy_o = busy;

  // the controller branches on the incoming op while idle
  always_comb begin
    sts_ctrl = sts;
    if (!busy) sts_ctrl.op_rd = cmd_i.op;
  end

  vga_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy),
    .done_o  (done_o),
    .ctl_o   (ctl),
    .sts_i   (sts_ctrl)
  );

  vga_datapath #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y),
    .GRID_Z (GRID_Z)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .result_o    (result_o)
  );

endmodule

// File: tb/sv/tb_voxel_grid_accumulator_core.sv
// self-checking testbench of the voxel grid accumulator core
module tb_voxel_grid_accumulator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import vga_pkg::*;

  localparam int unsigned GX = 64;
  localparam int unsigned GY = 64;
  localparam int unsigned GZ = 16;
  localparam longint unsigned CycleLimit = 4000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  vga_cmd_t    cmd_i = '0;
  logic        done_o;
  vga_res_t    result_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  voxel_grid_accumulator_core DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .cmd_i, .done_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // shadow of the block: registers and voxel store
  logic [31:0] org_x, org_y, org_z, inv_res;
  logic [15:0] thresh;
  bit [15:0]   vox_cnt [GX*GY*GZ];
  bit [23:0]   sum_r [GX*GY*GZ];
  bit [23:0]   sum_g [GX*GY*GZ];
  bit [23:0]   sum_b [GX*GY*GZ];
  bit [15:0]   hit_cells [$];

  vga_cmd_t    pending_cmds [$];
  vga_res_t    expected_res [$];
  int unsigned errors = 0;
  longint unsigned cycles = 0;
  bit          launched = 1'b0;
  int unsigned gap_left = 0;
  bit          burst = 1'b0;

  function automatic void add_cmd(vga_cmd_t c);
    pending_cmds = {pending_cmds, c};
  endfunction

  function automatic void add_exp(vga_res_t r);
    expected_res = {expected_res, r};
  endfunction

  function automatic int cell_of(logic [31:0] p, logic [31:0] r, int unsigned size);
    logic [32:0] d;
    logic [32:0] m;
    logic [63:0] pr;
    logic [31:0] im;
    d = {p[31], p} - {r[31], r};
    m = d[32] ? -d : d;
    pr = 64'(m) * 64'(inv_res);
    im = pr[63:32];
    if (d[32] && im != 0) return -1;
    if (im >= size) return -1;
    return int'(im);
  endfunction

  function automatic vga_res_t apply_cmd(vga_cmd_t c);
    vga_res_t r;
    int ix, iy, iz;
    int unsigned a;
    r = '0;
    if (c.op == OP_INSERT) begin
      ix = cell_of(c.pos_x, org_x, GX);
      iy = cell_of(c.pos_y, org_y, GY);
      iz = cell_of(c.pos_z, org_z, GZ);
      if (ix < 0 || iy < 0 || iz < 0) begin
        r.status = ST_OUTSIDE;
      end else begin
        a = (ix * GY + iy) * GZ + iz;
        if (vox_cnt[a] == CountMax) begin
          r.status = ST_FULL;
        end else begin
          vox_cnt[a]++;
          sum_r[a] += c.red;
          sum_g[a] += c.green;
          sum_b[a] += c.blue;
          if (hit_cells.size() < 512) hit_cells = {hit_cells, 16'(a)};
        end
        r.point_count = vox_cnt[a];
      end
    end else begin
      a = (c.cell_x * GY + c.cell_y) * GZ + c.cell_z;
      r.point_count = vox_cnt[a];
      if (vox_cnt[a] >= thresh) begin
        r.used = 1'b1;
        if (vox_cnt[a] != 0) begin
          r.avg_red   = 8'(sum_r[a] / vox_cnt[a]);
          r.avg_green = 8'(sum_g[a] / vox_cnt[a]);
          r.avg_blue  = 8'(sum_b[a] / vox_cnt[a]);
        end
      end
    end
    return r;
  endfunction

  function automatic vga_cmd_t junk_cmd();
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return vga_cmd_t'(raw[$bits(vga_cmd_t)-1:0]);
  endfunction

  function automatic vga_cmd_t insert_at(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    vga_cmd_t c;
    c = junk_cmd();
    c.op = OP_INSERT;
    c.pos_x = x;
    c.pos_y = y;
    c.pos_z = z;
    return c;
  endfunction

  function automatic vga_cmd_t read_at(logic [5:0] x, logic [5:0] y, logic [3:0] z);
    vga_cmd_t c;
    c = junk_cmd();
    c.op = OP_READ;
    c.cell_x = x;
    c.cell_y = y;
    c.cell_z = z;
    return c;
  endfunction

  // position that should fall into cell t along an axis, given the origin
  function automatic logic [31:0] aim(int t, logic [31:0] r);
    longint unsigned num;
    longint unsigned off;
    if (inv_res == 0) return $urandom;
    num = (longint'(t) << 32) + longint'($urandom);
    off = num / inv_res;
    return r + off[31:0];
  endfunction

  function automatic logic [31:0] aim_axis(logic [31:0] r, int unsigned size);
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 85) return aim($urandom_range(0, size - 1), r);
    if (k < 92) return aim(size + $urandom_range(0, 3), r);
    if (k < 96) return r - $urandom_range(1, 200000);
    return $urandom;
  endfunction

  function automatic int unsigned next_gap();
    int unsigned k;
    if ($urandom_range(0, 99) < 3) burst = ~burst;
    if (burst) return 0;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // command driver
  always @(negedge clk_i) begin
    logic nxt;
    nxt = start_i;
    if (launched) begin
      launched = 1'b0;
      void'(pending_cmds.pop_front());
      nxt = 1'b0;
      gap_left = next_gap();
    end
    if (!nxt && pending_cmds.size() > 0 && rst_ni) begin
      if (gap_left > 0) begin
        gap_left--;
      end else begin
        nxt = 1'b1;
        cmd_i <= pending_cmds[0];
      end
    end
    start_i <= nxt;
  end

  // transaction monitor and checker
  always @(posedge clk_i) begin
    vga_res_t e;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[voxel_grid_accumulator_core] ERROR");
      $finish;
    end
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        add_exp(apply_cmd(cmd_i));
        launched = 1'b1;
      end
      if (done_o) begin
        if (expected_res.size() == 0) begin
          $error("result with nothing expected: %p", result_o);
          errors++;
        end else begin
          e = expected_res.pop_front();
          if (result_o.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, result_o.status); errors++;
          end
          if (result_o.used !== e.used) begin
            $error("used exp %0d got %0d", e.used, result_o.used); errors++;
          end
          if (result_o.point_count !== e.point_count) begin
            $error("point_count exp %0d got %0d", e.point_count, result_o.point_count);
            errors++;
          end
          if (result_o.avg_red !== e.avg_red) begin
            $error("avg_red exp %0d got %0d", e.avg_red, result_o.avg_red); errors++;
          end
          if (result_o.avg_green !== e.avg_green) begin
            $error("avg_green exp %0d got %0d", e.avg_green, result_o.avg_green); errors++;
          end
          if (result_o.avg_blue !== e.avg_blue) begin
            $error("avg_blue exp %0d got %0d", e.avg_blue, result_o.avg_blue); errors++;
          end
        end
      end
    end
  end

  task automatic drain();
    while (pending_cmds.size() > 0 || start_i || expected_res.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_REF_X:   org_x = data;
      CFG_REF_Y:   org_y = data;
      CFG_REF_Z:   org_z = data;
      CFG_INV_RES: inv_res = data;
      CFG_MIN_PTS: thresh = data[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic setup(logic [31:0] rx, logic [31:0] ry, logic [31:0] rz,
                       logic [31:0] inv, logic [15:0] mp);
    drain();
    reg_write(CFG_REF_X, rx);
    reg_write(CFG_REF_Y, ry);
    reg_write(CFG_REF_Z, rz);
    reg_write(CFG_INV_RES, inv);
    reg_write(CFG_MIN_PTS, {16'($urandom_range(0, 65535)), mp});
  endtask

  task automatic random_mix(int n);
    bit [15:0] a;
    repeat (n) begin
      if ($urandom_range(0, 99) < 70) begin
        add_cmd(insert_at(aim_axis(org_x, GX), aim_axis(org_y, GY), aim_axis(org_z, GZ)));
      end else if (hit_cells.size() > 0 && $urandom_range(0, 99) < 75) begin
        a = hit_cells[$urandom_range(0, hit_cells.size() - 1)];
        add_cmd(read_at(a[15:10], a[9:4], a[3:0]));
      end else begin
        add_cmd(read_at(6'($urandom), 6'($urandom), 4'($urandom)));
      end
    end
  endtask

  initial begin
    org_x = '0; org_y = '0; org_z = '0;
    inv_res = InvResReset;
    thresh = MinPtsReset;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset settings: index is the integer part of the position
    add_cmd(read_at(6'd0, 6'd0, 4'd0));
    add_cmd(insert_at(32'h0, 32'h0, 32'h0));
    add_cmd(insert_at(32'hFFFF_FFFF, 32'hFFFF_8000, 32'h0000_FFFF));
    add_cmd(insert_at(32'h003F_FFFF, 32'h003F_FFFF, 32'h000F_FFFF));
    add_cmd(insert_at(32'h0040_0000, 32'h0, 32'h0));
    add_cmd(insert_at(32'h0, 32'h0, 32'h0010_0000));
    add_cmd(insert_at(32'hFFFF_0000, 32'h0, 32'h0));
    add_cmd(insert_at(32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
    begin
      vga_cmd_t c;
      c = insert_at(32'h0, 32'h0, 32'h0);
      c.red = 8'hFF; c.green = 8'h00; c.blue = 8'hFF;
      add_cmd(c);
      c.red = 8'h00; c.green = 8'hFF; c.blue = 8'h00;
      add_cmd(c);
    end
    add_cmd(read_at(6'd0, 6'd0, 4'd0));
    add_cmd(read_at(6'd63, 6'd63, 4'd15));
    add_cmd(read_at(6'd17, 6'd40, 4'd9));
    random_mix(200);

    setup($urandom, $urandom, $urandom, 32'h0004_0000, 16'd3);
    random_mix(220);
    setup(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_1000, 16'd0);
    add_cmd(read_at(6'd50, 6'd2, 4'd3));
    random_mix(220);
    setup(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 16'hFFFF);
    random_mix(200);
    setup(32'h7FFF_FFFF, 32'h8000_0000, $urandom, 32'h1, 16'd1);
    add_cmd(insert_at(32'h8000_0000, 32'h7FFF_FFFF, $urandom));
    random_mix(180);
    // zero inverse resolution folds every point into the first voxel
    setup($urandom, $urandom, $urandom, 32'h0, 16'd2);
    random_mix(40);
    add_cmd(read_at(6'd0, 6'd0, 4'd0));
    setup($urandom, $urandom, $urandom, 32'h0001_8000, 16'd5);
    random_mix(300);

    // reads at the top threshold
    setup(32'h0, 32'h0, 32'h0, InvResReset, 16'hFFFF);
    add_cmd(read_at(6'd5, 6'd5, 4'd5));
    add_cmd(read_at(6'd5, 6'd5, 4'd4));
    random_mix(30);

    drain();
    if (errors == 0) begin
      $display("[voxel_grid_accumulator_core] OK");
    end else begin
      $display("[voxel_grid_accumulator_core] ERROR");
    end
    $finish;
  end

endmodule
